// ===== hdl/shb_pkg.sv =====
package shb_pkg;

    localparam int unsigned COORD_W     = 32;
    localparam int unsigned SCALE_W     = 32;
    localparam int unsigned HALF_W      = SCALE_W / 2;
    localparam int unsigned MAG_W       = COORD_W + 1;
    localparam int unsigned CELL_W      = 31;
    localparam int unsigned KEY_W       = 32;
    localparam int unsigned N_W         = 25;
    localparam int unsigned REM_W       = 24;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned MOD_STEP    = 4;
    localparam int unsigned MOD_STAGES  = KEY_W / MOD_STEP;
    localparam int unsigned CELL_STAGES = 4;
    localparam int unsigned PIPE_STAGES = CELL_STAGES + 1 + MOD_STAGES;

    localparam logic [KEY_W-1:0] PRIME_X = 32'd73856093;
    localparam logic [KEY_W-1:0] PRIME_Y = 32'd19349663;
    localparam logic [KEY_W-1:0] PRIME_Z = 32'd83492791;

    localparam logic [N_W-1:0] N_MAX = 25'h1000000;
    localparam logic [N_W-1:0] N_MIN = 25'd1;

    typedef enum logic [IDX_W-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_ORIGIN_Z     = 3'd2,
        REG_CELL_SCALE   = 3'd3,
        REG_BUCKET_COUNT = 3'd4
    } reg_index_t;

    // Partial remainder and the key bits not yet shifted in.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [KEY_W-1:0] rest;
    } mod_state_t;

    // Shift in MOD_STEP key bits, one restoring step each. The partial
    // remainder stays below n, so one subtract per step suffices.
    function automatic mod_state_t mod_step(mod_state_t s, logic [N_W-1:0] n);
        mod_state_t     r;
        logic [N_W-1:0] t;
        r = s;
        for (int j = 0; j < MOD_STEP; j++)
        begin
            t = {r.rem, r.rest[KEY_W-1]};
            r.rest = {r.rest[KEY_W-2:0], 1'b0};
            if (t >= n)
            begin
                t = t - n;
            end
            r.rem = t[REM_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/shb_cell_axis.sv =====
module shb_cell_axis #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic [shb_pkg::CELL_STAGES-1:0]      en,
    input  logic [shb_pkg::COORD_W-1:0]          point,
    input  logic [shb_pkg::COORD_W-1:0]          origin,
    input  logic [shb_pkg::SCALE_W-1:0]          scale,
    input  logic [shb_pkg::KEY_W-1:0]            prime,
    output logic [shb_pkg::KEY_W-1:0]            hash
);

    localparam int unsigned PP_W   = shb_pkg::MAG_W + shb_pkg::HALF_W;
    localparam int unsigned PROD_W = PP_W + shb_pkg::HALF_W;
    localparam int unsigned SHIFT  = 2 * FRAC_BITS;

    logic [shb_pkg::MAG_W-1:0]  diff;
    logic [shb_pkg::MAG_W-1:0]  mag_next;
    logic [shb_pkg::MAG_W-1:0]  mag_reg;
    logic [PP_W-1:0]            pp_lo_next;
    logic [PP_W-1:0]            pp_hi_next;
    logic [PP_W-1:0]            pp_lo_reg;
    logic [PP_W-1:0]            pp_hi_reg;
    logic [PROD_W-1:0]          prod;
    logic [PROD_W-1:0]          shifted;
    logic                       sat;
    logic [shb_pkg::CELL_W-1:0] cell_next;
    logic [shb_pkg::CELL_W-1:0] cell_reg;
    logic [shb_pkg::KEY_W-1:0]  cell_ext;
    logic [shb_pkg::KEY_W-1:0]  hash_next;
    logic [shb_pkg::KEY_W-1:0]  hash_reg;

    // Distance from the origin, magnitude only.
    always_comb
    begin
        diff = {point[shb_pkg::COORD_W-1], point} - {origin[shb_pkg::COORD_W-1], origin};
        mag_next = diff[shb_pkg::MAG_W-1] ? (~diff + 1'b1) : diff;
    end

    // Split the scale into halves to keep each multiplier narrow.
    always_comb
    begin
        pp_lo_next = PP_W'(mag_reg) * PP_W'(scale[shb_pkg::HALF_W-1:0]);
        pp_hi_next = PP_W'(mag_reg) * PP_W'(scale[shb_pkg::SCALE_W-1:shb_pkg::HALF_W]);
    end

    // Recombine, drop the fraction bits, saturate.
    always_comb
    begin
        prod      = PROD_W'({pp_hi_reg, {shb_pkg::HALF_W{1'b0}}}) + PROD_W'(pp_lo_reg);
        shifted   = prod >> SHIFT;
        sat       = |shifted[PROD_W-1:shb_pkg::CELL_W];
        cell_next = sat ? {shb_pkg::CELL_W{1'b1}} : shifted[shb_pkg::CELL_W-1:0];
    end

    // Wrapping multiply by the axis prime.
    always_comb
    begin
        cell_ext  = shb_pkg::KEY_W'(cell_reg);
        hash_next = cell_ext * prime;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag_reg <= mag_next;
        end
        if (en[1])
        begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
        end
        if (en[2])
        begin
            cell_reg <= cell_next;
        end
        if (en[3])
        begin
            hash_reg <= hash_next;
        end
    end

    assign hash = hash_reg;

endmodule

// ===== hdl/shb_mod_pipe.sv =====
module shb_mod_pipe (
    input  logic                              clk,
    input  logic [shb_pkg::MOD_STAGES:0]      en,
    input  logic [shb_pkg::KEY_W-1:0]         hx,
    input  logic [shb_pkg::KEY_W-1:0]         hy,
    input  logic [shb_pkg::KEY_W-1:0]         hz,
    input  logic [shb_pkg::N_W-1:0]           n,
    output logic [shb_pkg::REM_W-1:0]         bucket_index
);

    logic [shb_pkg::KEY_W-1:0] key_reg;
    shb_pkg::mod_state_t       st_in  [shb_pkg::MOD_STAGES];
    shb_pkg::mod_state_t       st_reg [shb_pkg::MOD_STAGES];

    // Fold the three axis hashes into one key.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            key_reg <= hx ^ hy ^ hz;
        end
    end

    assign st_in[0] = '{rem: '0, rest: key_reg};

    for (genvar s = 0; s < shb_pkg::MOD_STAGES; s++)
    begin : g_stage
        if (s > 0)
        begin : g_link
            assign st_in[s] = st_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en[s+1])
            begin
                st_reg[s] <= shb_pkg::mod_step(st_in[s], n);
            end
        end
    end

    assign bucket_index = st_reg[shb_pkg::MOD_STAGES-1].rem;

endmodule

// ===== hdl/spatial_hash_bucket_index.sv =====
// Channel   Direction  Handshake               Payload
// -------   ---------  ---------------------   ----------------------------
// input     in         in_valid / in_stall     point_x, point_y, point_z
// result    out        out_valid / out_stall   bucket_index
// config    in         wr_en (no wait)         wr_index, wr_data
//
// One item per cycle sustained while out_stall is low. The pipeline holds
// four per-axis stages (offset/abs, split multiply, recombine/saturate,
// prime multiply), one XOR stage and eight remainder stages that each
// retire four key bits. Reset clears the valid bits and loads the register
// defaults. A stall holds only the stages that are full and blocked; empty
// stages keep filling, so bubbles collapse under a stall.
module spatial_hash_bucket_index #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [shb_pkg::COORD_W-1:0]   point_x,
    input  logic [shb_pkg::COORD_W-1:0]   point_y,
    input  logic [shb_pkg::COORD_W-1:0]   point_z,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [shb_pkg::REM_W-1:0]     bucket_index,

    input  logic                          wr_en,
    input  logic [shb_pkg::IDX_W-1:0]     wr_index,
    input  logic [shb_pkg::SCALE_W-1:0]   wr_data
);

    localparam int unsigned NS = shb_pkg::PIPE_STAGES;
    localparam int unsigned CS = shb_pkg::CELL_STAGES;

    localparam logic [shb_pkg::SCALE_W-1:0] SCALE_ONE =
        shb_pkg::SCALE_W'(64'd1 << FRAC_BITS);

    logic [shb_pkg::COORD_W-1:0] origin_x_reg;
    logic [shb_pkg::COORD_W-1:0] origin_y_reg;
    logic [shb_pkg::COORD_W-1:0] origin_z_reg;
    logic [shb_pkg::SCALE_W-1:0] scale_reg;
    logic [shb_pkg::N_W-1:0]     n_reg;
    logic [shb_pkg::N_W-1:0]     n_next;

    logic [NS-1:0]               valid_reg;
    logic [NS-1:0]               ready;

    logic [shb_pkg::KEY_W-1:0]   hx;
    logic [shb_pkg::KEY_W-1:0]   hy;
    logic [shb_pkg::KEY_W-1:0]   hz;

    // Clamp the bucket count once at write time, from the low 25 bits of wr_data:
    // zero acts as one, and anything above 2^24 acts as 2^24 so the index always fits.
    always_comb
    begin
        n_next = wr_data[shb_pkg::N_W-1:0];
        if (n_next == '0)
        begin
            n_next = shb_pkg::N_MIN;
        end
        else if (n_next > shb_pkg::N_MAX)
        begin
            n_next = shb_pkg::N_MAX;
        end
    end

    // Configuration registers; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            scale_reg    <= SCALE_ONE;
            n_reg        <= shb_pkg::N_MIN;
        end
        else if (wr_en)
        begin
            unique case (shb_pkg::reg_index_t'(wr_index))
                shb_pkg::REG_ORIGIN_X:     origin_x_reg <= wr_data;
                shb_pkg::REG_ORIGIN_Y:     origin_y_reg <= wr_data;
                shb_pkg::REG_ORIGIN_Z:     origin_z_reg <= wr_data;
                shb_pkg::REG_CELL_SCALE:   scale_reg    <= wr_data;
                shb_pkg::REG_BUCKET_COUNT: n_reg        <= n_next;
                default:
                begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or its successor loads this cycle.
    // The last stage is the output register and yields to out_stall.
    for (genvar i = 0; i < NS; i++)
    begin : g_ready
        if (i == NS - 1)
        begin : g_last
            assign ready[i] = !valid_reg[i] || !out_stall;
        end
        else
        begin : g_mid
            assign ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    // Advance valid bits alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[NS-1];

    // One cell pipeline per axis.
    shb_cell_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_x (
        .clk    (clk),
        .en     (ready[CS-1:0]),
        .point  (point_x),
        .origin (origin_x_reg),
        .scale  (scale_reg),
        .prime  (shb_pkg::PRIME_X),
        .hash   (hx)
    );

    shb_cell_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_y (
        .clk    (clk),
        .en     (ready[CS-1:0]),
        .point  (point_y),
        .origin (origin_y_reg),
        .scale  (scale_reg),
        .prime  (shb_pkg::PRIME_Y),
        .hash   (hy)
    );

    shb_cell_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_z (
        .clk    (clk),
        .en     (ready[CS-1:0]),
        .point  (point_z),
        .origin (origin_z_reg),
        .scale  (scale_reg),
        .prime  (shb_pkg::PRIME_Z),
        .hash   (hz)
    );

    // XOR the axis hashes and reduce modulo the bucket count.
    shb_mod_pipe u_mod (
        .clk          (clk),
        .en           (ready[NS-1:CS]),
        .hx           (hx),
        .hy           (hy),
        .hz           (hz),
        .n            (n_reg),
        .bucket_index (bucket_index)
    );

endmodule
